/* rtl/bsa_pkg.sv */
// Package for the bounding sphere accumulator: widths, payload structs,
// request/relation codes, controller states and command/status structs.
package bsa_pkg;
  localparam int CW = 32;
  localparam int RW = CW - 1;
  localparam int DW = CW + 1;          // axis difference magnitude
  localparam int SW = 2 * DW + 2;      // sum of three squares
  localparam int QW = CW + 1;          // root width
  localparam int TOL_W = 16;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EXT_SPHERE = 2'd1;
  localparam logic [1:0] REQ_EXT_POINT = 2'd2;
  localparam logic [1:0] REQ_TRANSLATE = 2'd3;

  localparam logic [2:0] REL_APART = 3'd0;
  localparam logic [2:0] REL_OVERLAP = 3'd1;
  localparam logic [2:0] REL_TOUCH = 3'd2;
  localparam logic [2:0] REL_STORED_IN = 3'd3;
  localparam logic [2:0] REL_INPUT_IN = 3'd4;
  localparam logic [2:0] REL_PT_IN = 3'd1;
  localparam logic [2:0] REL_PT_ON = 3'd2;

  localparam logic [1:0] REG_TOL = 2'd0;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic [RW-1:0] in_radius;
  } in_item_t;

  typedef struct packed {
    logic [2:0] relation;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [RW-1:0] out_radius;
    logic saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQ_ACC, ST_SQRT, ST_CLASS, ST_MUL, ST_DIV, ST_NEXT_AXIS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;      // capture input item
    logic sq;         // square one axis difference
    logic sq_acc;     // add square into sum
    logic sqrt_init;
    logic sqrt_step;
    logic classify;   // relation + simple updates
    logic mul;        // |delta| * k
    logic div_step;
    logic axis_done;  // write moved axis
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic needs_dist;
    logic needs_move;
    logic last_axis;
    logic step_last;
  } status_t;
endpackage

/* rtl/bsa_ctrl.sv */
// Controller for the bounding sphere accumulator.
// Depends on bsa_pkg for state, command and status types.
module bsa_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  bsa_pkg::status_t sts,
  output bsa_pkg::cmd_t cmd
);
  import bsa_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sts.needs_dist) begin
          cmd.sq = 1'b1;
          state_nxt = ST_SQ_ACC;
        end else state_nxt = ST_CLASS;
      end
      ST_SQ_ACC: begin
        // the last square is added by the root start itself
        if (sts.last_axis) begin
          cmd.sqrt_init = 1'b1;
          state_nxt = ST_SQRT;
        end else begin
          cmd.sq_acc = 1'b1;
          state_nxt = ST_SQ;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_last) state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (sts.needs_move) begin
          cmd.mul = 1'b1;
          state_nxt = ST_DIV;
        end else state_nxt = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = ST_NEXT_AXIS;
      end
      ST_NEXT_AXIS: begin
        cmd.axis_done = 1'b1;
        state_nxt = sts.last_axis ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

/* rtl/bsa_datapath.sv */
// Datapath for the bounding sphere accumulator: sphere state, squares,
// bit-serial square root and restoring divider. Depends on bsa_pkg.
module bsa_datapath (
  input  logic clk,
  input  logic rst_n,
  input  bsa_pkg::in_item_t in_item,
  input  logic [bsa_pkg::TOL_W-1:0] tol,
  input  bsa_pkg::cmd_t cmd,
  output bsa_pkg::status_t sts,
  output bsa_pkg::out_item_t out_item,
  output logic out_valid
);
  import bsa_pkg::*;

  localparam int PW = DW + QW;  // product |delta| * k
  localparam int CNT_W = $clog2(PW + 1);

  in_item_t item_r;
  logic signed [CW-1:0] cen_r [3];
  logic signed [CW-1:0] cen_nxt [3];
  logic sat_any;
  logic [RW-1:0] rad_r;
  logic [1:0] axis_r;
  logic [2*DW-1:0] sq_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] root_r;
  logic [SW-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2:0] rel_r;
  logic sat_r;
  logic move_r;
  logic [QW-1:0] k_r;
  logic [PW-1:0] num_r;
  logic [QW:0] drem_r;
  logic [PW-1:0] quo_r;
  logic neg_r;
  logic valid_r;

  // per-axis difference, input minus stored
  logic signed [CW:0] delta;
  logic [DW-1:0] dmag;
  always_comb begin
    logic signed [CW-1:0] ci;
    case (axis_r)
      2'd0: ci = item_r.in_x;
      2'd1: ci = item_r.in_y;
      default: ci = item_r.in_z;
    endcase
    delta = {ci[CW-1], ci} - {cen_r[axis_r][CW-1], cen_r[axis_r]};
    dmag = delta[CW] ? DW'(-delta) : DW'(delta);
  end

  // square root step: two bits of the radicand each cycle
  logic [SW-1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_r[SW-3:0], 2'b00} | SW'(sum_r[SW-1:SW-2]);
    trial = SW'({root_r, 2'b01});
  end

  // relation
  logic [QW+1:0] d_w, rs_w, ri_w, sum_w, tol_w;
  assign d_w = (QW+2)'(root_r);
  assign rs_w = (QW+2)'(rad_r);
  assign ri_w = (QW+2)'(item_r.in_radius);
  assign sum_w = rs_w + ri_w;
  assign tol_w = (QW+2)'(tol);

  // divider step
  logic [QW:0] drem_sh;
  assign drem_sh = {drem_r[QW-1:0], num_r[PW-1]};

  assign sts.needs_dist = (item_r.req_type == REQ_EXT_SPHERE) ||
                          (item_r.req_type == REQ_EXT_POINT);
  assign sts.needs_move = move_r;
  assign sts.last_axis = (axis_r == 2'd2);
  assign sts.step_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0; cen_r[1] <= '0; cen_r[2] <= '0;
      rad_r <= '0;
      valid_r <= 1'b0;
      axis_r <= '0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.latch) begin
        item_r <= in_item;
        axis_r <= '0;
        sum_r <= '0;
        sat_r <= 1'b0;
        rel_r <= REL_APART;
        move_r <= 1'b0;
      end
      if (cmd.sq) sq_r <= dmag * dmag;
      if (cmd.sq_acc) begin
        sum_r <= sum_r + SW'(sq_r);
        axis_r <= axis_r + 2'd1;
      end
      if (cmd.sqrt_init) begin
        sum_r <= sum_r + SW'(sq_r);
        root_r <= '0;
        rem_r <= '0;
        cnt_r <= CNT_W'(SW / 2 - 1);
        axis_r <= '0;
      end
      if (cmd.sqrt_step) begin
        sum_r <= {sum_r[SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r <= rem_sh - trial;
          root_r <= {root_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root_r <= {root_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.classify) begin
        axis_r <= '0;
        case (item_r.req_type)
          REQ_LOAD: begin
            cen_r[0] <= item_r.in_x; cen_r[1] <= item_r.in_y;
            cen_r[2] <= item_r.in_z; rad_r <= item_r.in_radius;
          end
          REQ_EXT_SPHERE: begin
            if (d_w + ri_w <= rs_w) rel_r <= REL_INPUT_IN;
            else if (d_w + rs_w <= ri_w) begin
              rel_r <= REL_STORED_IN;
              cen_r[0] <= item_r.in_x; cen_r[1] <= item_r.in_y;
              cen_r[2] <= item_r.in_z; rad_r <= item_r.in_radius;
            end else begin
              logic [QW+2:0] nr;
              nr = ((QW+3)'(d_w) + (QW+3)'(sum_w)) >> 1;
              if (d_w < sum_w) rel_r <= REL_OVERLAP;
              else if (d_w - sum_w < tol_w) rel_r <= REL_TOUCH;
              else rel_r <= REL_APART;
              if (nr > (QW+3)'({RW{1'b1}})) begin
                rad_r <= {RW{1'b1}}; sat_r <= 1'b1;
              end else rad_r <= nr[RW-1:0];
              k_r <= QW'((d_w + ri_w - rs_w) >> 1);
              move_r <= 1'b1;
            end
          end
          REQ_EXT_POINT: begin
            if (d_w < rs_w) rel_r <= REL_PT_IN;
            else if (d_w - rs_w < tol_w) rel_r <= REL_PT_ON;
            else begin
              rel_r <= REL_APART;
              if (d_w > (QW+2)'({RW{1'b1}})) begin
                rad_r <= {RW{1'b1}}; sat_r <= 1'b1;
              end else rad_r <= d_w[RW-1:0];
            end
          end
          default: begin
            for (int a = 0; a < 3; a++) cen_r[a] <= cen_nxt[a];
            if (sat_any) sat_r <= 1'b1;
          end
        endcase
      end
      if (cmd.mul) begin
        num_r <= PW'(dmag) * PW'(k_r);
        neg_r <= delta[CW];
        drem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_W'(PW - 1);
      end
      if (cmd.div_step) begin
        num_r <= {num_r[PW-2:0], 1'b0};
        if (drem_sh >= (QW+1)'(root_r) && root_r != '0) begin
          drem_r <= drem_sh - (QW+1)'(root_r);
          quo_r <= {quo_r[PW-2:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          quo_r <= {quo_r[PW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.axis_done) begin
        logic [CW:0] off;
        off = (CW+1)'(quo_r);
        if (neg_r) cen_r[axis_r] <= CW'({cen_r[axis_r][CW-1], cen_r[axis_r]} - off);
        else cen_r[axis_r] <= CW'({cen_r[axis_r][CW-1], cen_r[axis_r]} + off);
        axis_r <= axis_r + 2'd1;
      end
    end
  end

  // saturating translate
  always_comb begin
    logic signed [CW:0] s;
    logic [CW-1:0] v;
    sat_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      case (a)
        0: v = item_r.in_x;
        1: v = item_r.in_y;
        default: v = item_r.in_z;
      endcase
      s = {cen_r[a][CW-1], cen_r[a]} + {v[CW-1], v};
      if (s[CW] != s[CW-1]) begin
        sat_any = 1'b1;
        cen_nxt[a] = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else cen_nxt[a] = s[CW-1:0];
    end
  end

  assign out_valid = valid_r;
  assign out_item.relation = rel_r;
  assign out_item.out_x = cen_r[0];
  assign out_item.out_y = cen_r[1];
  assign out_item.out_z = cen_r[2];
  assign out_item.out_radius = rad_r;
  assign out_item.saturated = sat_r;
endmodule

/* rtl/bounding_sphere_accumulator.sv */
// Bounding sphere accumulator: one stored sphere updated by load, extend
// and translate requests. Load and translate skip the squares and the root;
// an extend by point or a contained sphere first squares the three axis
// differences and takes a 34-step two-bit-per-cycle square root; a sphere
// merge then adds three axis moves, each around a 66-step restoring
// division. One item at a time: busy is high from accept until the result
// strobe, and no item is taken while it is high. Synchronous active-low
// reset clears the sphere and sets tolerance to 1.
module bounding_sphere_accumulator (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  bsa_pkg::in_item_t in_item,
  output logic out_strobe,
  output bsa_pkg::out_item_t out_item,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import bsa_pkg::*;

  cmd_t cmd;
  status_t sts;
  logic [TOL_W-1:0] tol_r;

  // Register file: one tolerance register at byte address 0.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_W'(1);
    else if (psel && penable && pwrite && paddr[1:0] == {REG_TOL[1:0]})
      tol_r <= pwdata[TOL_W-1:0];
  end
  // Return the register on its address, zero elsewhere.
  assign prdata = (paddr == REG_TOL) ? 32'(tol_r) : 32'd0;

  // Sequence each transfer through the datapath.
  bsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  bsa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .tol(tol_r), .cmd(cmd),
    .sts(sts), .out_item(out_item), .out_valid(out_strobe)
  );
endmodule

/* rtl/bsa_checker.sv */
// Port-level checks for the bounding sphere accumulator.
// Depends on bsa_pkg; bound to the top level below.
module bsa_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input bsa_pkg::out_item_t out_item,
  input logic pready
);
  import bsa_pkg::*;
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy missing after transfer");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe longer than a cycle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without item");
  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.relation <= REL_INPUT_IN) else $error("bad relation");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind bounding_sphere_accumulator bsa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item), .pready(pready)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bounding_sphere_accumulator: directed table, then random requests.
// Depends on rtl/bsa_pkg.sv and rtl/bounding_sphere_accumulator.sv.
module tb_top;
  import bsa_pkg::*;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [RW-1:0] R_MAX = {RW{1'b1}};
  localparam int ONE = 1 << 16;          // 1.0 in Q15.16
  localparam int N_RANDOM = 600;
  localparam int QUIET_TAIL = 100;       // last random items go without gaps
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = REG_TOL;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bounding_sphere_accumulator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the stored sphere and the tolerance register.
  logic signed [CW-1:0] sph_x, sph_y, sph_z;
  logic [RW-1:0] sph_r;
  logic [TOL_W-1:0] tol;

  out_item_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor(sqrt(dx^2 + dy^2 + dz^2)), exact
  function automatic longint unsigned center_gap(in_item_t it);
    logic [69:0] acc, cand;
    logic [69:0] ax, ay, az;
    logic [34:0] root;
    ax = mag(longint'(sph_x) - longint'(it.in_x));
    ay = mag(longint'(sph_y) - longint'(it.in_y));
    az = mag(longint'(sph_z) - longint'(it.in_z));
    acc = ax * ax + ay * ay + az * az;
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      cand = root | (35'd1 << i);
      if (cand * cand <= acc) root = cand[34:0];
    end
    return root;
  endfunction

  // Move one axis toward the input center by |delta|*k/d, truncated toward zero.
  function automatic logic signed [CW-1:0] slide(longint from, longint to,
                                                 longint unsigned k, longint unsigned d);
    logic [69:0] prod;
    longint delta, off;
    delta = to - from;
    prod = 70'(mag(delta)) * 70'(k);
    off = (d == 0) ? 0 : longint'(prod / 70'(d));
    return delta < 0 ? CW'(from - off) : CW'(from + off);
  endfunction

  function automatic logic signed [CW-1:0] sat_add(longint a, longint b, inout logic sat);
    longint s;
    s = a + b;
    if (s > longint'(C_MAX)) begin
      s = C_MAX;
      sat = 1'b1;
    end
    if (s < longint'(C_MIN)) begin
      s = C_MIN;
      sat = 1'b1;
    end
    return CW'(s);
  endfunction

  // Work out the result of one request and advance the shadow sphere.
  function automatic out_item_t next_sphere(in_item_t it);
    out_item_t res;
    longint unsigned d, rs, ri, sum, nr, k;
    logic [2:0] rel;
    logic sat;
    rel = REL_APART;
    sat = 1'b0;
    rs = sph_r;
    ri = it.in_radius;
    case (it.req_type)
      REQ_LOAD: begin
        {sph_x, sph_y, sph_z, sph_r} = {it.in_x, it.in_y, it.in_z, it.in_radius};
      end
      REQ_EXT_SPHERE: begin
        d = center_gap(it);
        sum = rs + ri;
        if (d + ri <= rs) rel = REL_INPUT_IN;
        else if (d + rs <= ri) rel = REL_STORED_IN;
        else if (d < sum) rel = REL_OVERLAP;
        else if (d - sum < tol) rel = REL_TOUCH;
        if (rel == REL_STORED_IN) begin
          {sph_x, sph_y, sph_z, sph_r} = {it.in_x, it.in_y, it.in_z, it.in_radius};
        end else if (rel != REL_INPUT_IN) begin
          nr = (d + sum) >> 1;
          k = (d + ri - rs) >> 1;
          sph_x = slide(sph_x, it.in_x, k, d);
          sph_y = slide(sph_y, it.in_y, k, d);
          sph_z = slide(sph_z, it.in_z, k, d);
          if (nr > R_MAX) begin
            nr = R_MAX;
            sat = 1'b1;
          end
          sph_r = RW'(nr);
        end
      end
      REQ_EXT_POINT: begin
        d = center_gap(it);
        if (d < rs) rel = REL_PT_IN;
        else if (d - rs < tol) rel = REL_PT_ON;
        if (rel == REL_APART) begin
          if (d > R_MAX) begin
            d = R_MAX;
            sat = 1'b1;
          end
          sph_r = RW'(d);
        end
      end
      default: begin
        sph_x = sat_add(sph_x, it.in_x, sat);
        sph_y = sat_add(sph_y, it.in_y, sat);
        sph_z = sat_add(sph_z, it.in_z, sat);
      end
    endcase
    res.relation = rel;
    res.out_x = sph_x;
    res.out_y = sph_y;
    res.out_z = sph_z;
    res.out_radius = sph_r;
    res.saturated = sat;
    return res;
  endfunction

  // Check each result transfer against the oldest pending prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %p", out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.relation !== want.relation) begin
          $error("relation: expected %0d, got %0d", want.relation, out_item.relation);
          errors++;
        end
        if (out_item.out_x !== want.out_x) begin
          $error("out_x: expected %0d, got %0d", want.out_x, out_item.out_x);
          errors++;
        end
        if (out_item.out_y !== want.out_y) begin
          $error("out_y: expected %0d, got %0d", want.out_y, out_item.out_y);
          errors++;
        end
        if (out_item.out_z !== want.out_z) begin
          $error("out_z: expected %0d, got %0d", want.out_z, out_item.out_z);
          errors++;
        end
        if (out_item.out_radius !== want.out_radius) begin
          $error("out_radius: expected %0d, got %0d", want.out_radius, out_item.out_radius);
          errors++;
        end
        if (out_item.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_item.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request; hold start until the transfer, leave it high for the caller.
  task automatic issue(in_item_t it, logic typed, out_item_t typed_res);
    out_item_t pred;
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pred = next_sphere(it);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drain, then write the tolerance register with a setup and an access phase.
  task automatic set_tolerance(logic [TOL_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_TOL;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol = value;
  endtask

  function automatic in_item_t mk(logic [1:0] req, logic signed [CW-1:0] x,
                                  logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                  logic [RW-1:0] r);
    in_item_t it;
    it.req_type = req;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    it.in_radius = r;
    return it;
  endfunction

  function automatic out_item_t res_of(logic [2:0] rel, logic signed [CW-1:0] x,
                                      logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                      logic [RW-1:0] r, logic sat);
    out_item_t o;
    o.relation = rel;
    o.out_x = x;
    o.out_y = y;
    o.out_z = z;
    o.out_radius = r;
    o.saturated = sat;
    return o;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 1 << 21) - (1 << 20);
  endfunction

  function automatic logic [RW-1:0] rand_radius();
    if ($urandom_range(0, 7) == 0) return RW'($urandom);
    return RW'($urandom_range(0, 1 << 20));
  endfunction

  // Some loads, growth requests near the stored sphere, some at a gap of zero
  // to three beyond touching, the rest wide noise.
  function automatic in_item_t rand_request();
    in_item_t it;
    longint off;
    it = mk(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(), rand_radius());
    case ($urandom_range(0, 9))
      0: it.req_type = REQ_LOAD;
      1, 2: begin
        it.req_type = 2'($urandom_range(REQ_EXT_SPHERE, REQ_EXT_POINT));
        it.in_radius = RW'($urandom_range(0, 1 << 18));
        off = longint'(sph_r) + $urandom_range(0, 3)
              + (it.req_type == REQ_EXT_SPHERE ? longint'(it.in_radius) : 0);
        if (longint'(sph_x) + off <= longint'(C_MAX)) begin
          it.in_x = CW'(longint'(sph_x) + off);
          it.in_y = sph_y;
          it.in_z = sph_z;
        end
      end
      3, 4, 5: begin
        it.req_type = 2'($urandom_range(REQ_EXT_SPHERE, REQ_EXT_POINT));
        it.in_x = sph_x + $urandom_range(0, 1 << 19) - (1 << 18);
        it.in_y = sph_y + $urandom_range(0, 1 << 19) - (1 << 18);
        it.in_z = sph_z + $urandom_range(0, 1 << 19) - (1 << 18);
      end
      default: ;
    endcase
    return it;
  endfunction

  typedef struct {
    in_item_t it;
    logic typed;
    out_item_t res;
  } dir_row_t;

  dir_row_t rows[$];

  initial begin
    int r100;
    r100 = 100 * ONE;
    tol = 1;
    sph_x = '0;
    sph_y = '0;
    sph_z = '0;
    sph_r = '0;

    // Directed rows: typed expectations where the answer is plain.
    rows = '{
      '{mk(REQ_TRANSLATE, 0, 0, 0, 0), 1'b1, res_of(REL_APART, 0, 0, 0, 0, 1'b0)},
      '{mk(REQ_LOAD, C_MAX, C_MIN, 0, R_MAX), 1'b1,
        res_of(REL_APART, C_MAX, C_MIN, 0, R_MAX, 1'b0)},
      '{mk(REQ_TRANSLATE, C_MAX, C_MIN, -1, 0), 1'b1,
        res_of(REL_APART, C_MAX, C_MIN, -1, R_MAX, 1'b1)},
      '{mk(REQ_LOAD, 0, 0, 0, r100), 1'b1, res_of(REL_APART, 0, 0, 0, r100, 1'b0)},
      '{mk(REQ_EXT_SPHERE, 10 * ONE, 0, 0, 5 * ONE), 1'b1,
        res_of(REL_INPUT_IN, 0, 0, 0, r100, 1'b0)},
      '{mk(REQ_EXT_SPHERE, ONE, 2, -3, 2 * r100), 1'b1,
        res_of(REL_STORED_IN, ONE, 2, -3, 2 * r100, 1'b0)},
      '{mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_EXT_SPHERE, 2 * r100, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_EXT_SPHERE, 3 * r100, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_EXT_SPHERE, r100, r100, 7, r100), 1'b0, '0},
      '{mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0},
      '{mk(REQ_EXT_POINT, r100, 0, 0, 0), 1'b1, res_of(REL_PT_ON, 0, 0, 0, r100, 1'b0)},
      '{mk(REQ_EXT_POINT, 0, 50 * ONE, 0, 0), 1'b1, res_of(REL_PT_IN, 0, 0, 0, r100, 1'b0)},
      '{mk(REQ_EXT_POINT, -3, 0, 4 * r100, 0), 1'b0, '0},
      '{mk(REQ_LOAD, C_MIN, C_MIN, C_MIN, R_MAX), 1'b0, '0},
      '{mk(REQ_EXT_POINT, C_MAX, C_MAX, C_MAX, 0), 1'b0, '0},
      '{mk(REQ_LOAD, C_MIN, C_MIN, C_MIN, R_MAX), 1'b0, '0},
      '{mk(REQ_EXT_SPHERE, C_MAX, C_MAX, C_MAX, R_MAX), 1'b0, '0},
      '{mk(REQ_TRANSLATE, C_MIN, C_MIN, C_MIN, R_MAX), 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      issue(rows[i].it, rows[i].typed, rows[i].res);
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 13));
    end

    // Zero tolerance: touching counts as apart.
    set_tolerance(0);
    issue(mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0);
    issue(mk(REQ_EXT_SPHERE, 2 * r100, 0, 0, r100), 1'b0, '0);
    issue(mk(REQ_LOAD, 0, 0, 0, r100), 1'b0, '0);
    issue(mk(REQ_EXT_POINT, r100, 0, 0, 0), 1'b0, '0);

    // Random phases, each under its own tolerance.
    for (int n = 0; n < N_RANDOM; n++) begin
      case (n)
        0: set_tolerance(16'hffff);
        150: set_tolerance(16'($urandom));
        300: set_tolerance(0);
        450: set_tolerance(1);
        default: ;
      endcase
      issue(rand_request(), 1'b0, '0);
      if (n < N_RANDOM - QUIET_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 13));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
